// ----- rtl/tmi_pkg.sv -----
// Shared constants and helpers of the tape machine interpreter.
// Used by the top level; depends on nothing.
package tmi_pkg;

    localparam int PROGRAM_DEPTH_DEF = 4096;
    localparam int TAPE_DEPTH_DEF    = 32768;
    localparam int CELL_BITS_DEF     = 32;

    localparam logic [15:0] TAPE_SIZE_RST = 16'd30000;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_SUPPLY = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [0:0] REG_TAPE_SIZE      = 1'd0;
    localparam logic [0:0] REG_CHECK_BRACKETS = 1'd1;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_OUTPUT     = 3'd1;
    localparam logic [2:0] ST_NEED_INPUT = 3'd2;
    localparam logic [2:0] ST_HALTED     = 3'd3;
    localparam logic [2:0] ST_BRACKET    = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;

    localparam logic [1:0] PH_LOADING = 2'd0;
    localparam logic [1:0] PH_RUNNING = 2'd1;
    localparam logic [1:0] PH_WAITING = 2'd2;
    localparam logic [1:0] PH_HALTED  = 2'd3;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    function automatic logic is_command(input logic [7:0] ch);
        return ch == CH_RIGHT || ch == CH_LEFT || ch == CH_INC || ch == CH_DEC ||
               ch == CH_OUT || ch == CH_IN || ch == CH_OPEN || ch == CH_CLOSE;
    endfunction

endpackage

// ----- rtl/tmi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stands alone; instanced for the program store and the tape.
module tmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/tape_machine_interpreter.sv -----
// Top level of the tape machine interpreter: sequencer, pointer unit, result register.
// Depends on tmi_pkg and tmi_ram (program store and tape).
//
// Usage: items enter on s_tvalid/s_tready; s_tuser carries the opcode (load, run,
// supply) and s_tdata the data byte and end-of-input flag. Each item gives exactly
// one result on m_tvalid/m_tready; m_tuser is the status, m_tdata the output byte.
// Registers (tape size, bracket check) are written on cfg_valid/cfg_ready; the user
// must write them only while idle, as the block itself does not enforce this.
// A run from the start first checks the brackets over the program bytes, when the
// check is enabled, then clears the tape cells in use and executes the commands;
// a bracket scan walks the program bytes to the matching bracket. Run-continue and
// supply first reduce the cell pointer against the tape size; cells added by a
// larger tape size are cleared the same way before execution goes on.
// Throughput: one item at a time; s_tready is low while an item is at work.
// Reset clears the program length, pointer and phase and presets the registers; tape
// contents are cleared at every run start, so no clearing pass follows reset.
// A stalled receiver holds the result in the output register; the block then takes
// the next item but holds its result until the previous one is taken.
module tape_machine_interpreter #(
    parameter int PROGRAM_DEPTH = tmi_pkg::PROGRAM_DEPTH_DEF,
    parameter int TAPE_DEPTH    = tmi_pkg::TAPE_DEPTH_DEF,
    parameter int CELL_BITS     = tmi_pkg::CELL_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] end_of_input, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PA = $clog2(PROGRAM_DEPTH);
    localparam int LW = PA + 1;
    localparam int TA = $clog2(TAPE_DEPTH);
    localparam int SW = TA + 1;
    localparam int KW = $clog2(TA);
    localparam int DW = 2 * TA + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHK_RD  = 4'd1;
    localparam logic [3:0] S_CHK     = 4'd2;
    localparam logic [3:0] S_CLR     = 4'd3;
    localparam logic [3:0] S_MOD     = 4'd4;
    localparam logic [3:0] S_FETCH   = 4'd5;
    localparam logic [3:0] S_DEC     = 4'd6;
    localparam logic [3:0] S_SCAN_RD = 4'd7;
    localparam logic [3:0] S_SCAN    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           phase_reg, phase_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        pc_reg, pc_next;
    logic [LW-1:0]        idx_reg, idx_next;
    logic [LW-1:0]        depth_reg, depth_next;
    logic [TA-1:0]        ptr_reg, ptr_next;
    logic [SW-1:0]        fill_reg, fill_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 back_reg, back_next;
    logic                 sup_reg, sup_next;
    logic [7:0]           sup_byte_reg, sup_byte_next;
    logic                 sup_eof_reg, sup_eof_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [7:0]           res_byte_reg, res_byte_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;
    logic [7:0]           m_tdata_reg, m_tdata_next;
    logic [15:0]          tape_size_reg, tape_size_next;
    logic                 check_reg, check_next;

    logic [16:0]          size_wide;
    logic [SW-1:0]        size;
    logic [DW-1:0]        sub_shifted;
    logic [DW-1:0]        sub_diff;

    logic                 prog_we;
    logic [PA-1:0]        prog_waddr, prog_raddr;
    logic [7:0]           prog_wdata, prog_rdata;
    logic                 tape_we;
    logic [TA-1:0]        tape_waddr;
    logic [CELL_BITS-1:0] tape_wdata, tape_rdata;

    always_comb begin
        if (tape_size_reg == 16'd0) begin
            size_wide = 17'd1;
        end else if ({1'b0, tape_size_reg} > 17'(TAPE_DEPTH)) begin
            size_wide = 17'(TAPE_DEPTH);
        end else begin
            size_wide = {1'b0, tape_size_reg};
        end
    end
    assign size = size_wide[SW-1:0];

    assign sub_shifted = DW'(size) << k_reg;
    assign sub_diff    = DW'(ptr_reg) - sub_shifted;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    tmi_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .aclk  (aclk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    tmi_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape (
        .aclk  (aclk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (ptr_reg),
        .rdata (tape_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        len_next        = len_reg;
        pc_next         = pc_reg;
        idx_next        = idx_reg;
        depth_next      = depth_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        back_next       = back_reg;
        sup_next        = sup_reg;
        sup_byte_next   = sup_byte_reg;
        sup_eof_next    = sup_eof_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        tape_size_next  = tape_size_reg;
        check_next      = check_reg;
        prog_we         = 1'b0;
        prog_waddr      = len_reg[PA-1:0];
        prog_wdata      = s_tdata[7:0];
        prog_raddr      = pc_reg[PA-1:0];
        tape_we         = 1'b0;
        tape_waddr      = ptr_reg;
        tape_wdata      = '0;

        if (cfg_valid) begin
            case (cfg_index)
                tmi_pkg::REG_TAPE_SIZE:      tape_size_next = cfg_data;
                tmi_pkg::REG_CHECK_BRACKETS: check_next = cfg_data[0];
                default:                     check_next = check_reg;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_status_next = tmi_pkg::ST_ACCEPTED;
                    res_byte_next   = 8'd0;
                    sup_next        = 1'b0;
                    state_next      = S_OUT;
                    case (s_tuser)
                        tmi_pkg::OP_LOAD: begin
                            if (phase_reg == tmi_pkg::PH_RUNNING ||
                                phase_reg == tmi_pkg::PH_WAITING) begin
                                phase_next = tmi_pkg::PH_LOADING;
                            end
                            if (tmi_pkg::is_command(s_tdata[7:0])) begin
                                if (len_reg >= LW'(PROGRAM_DEPTH)) begin
                                    res_status_next = tmi_pkg::ST_FULL;
                                end else begin
                                    prog_we  = 1'b1;
                                    len_next = len_reg + 1'b1;
                                end
                            end
                        end
                        tmi_pkg::OP_RUN: begin
                            if (phase_reg == tmi_pkg::PH_WAITING) begin
                                res_status_next = tmi_pkg::ST_NEED_INPUT;
                            end else if (phase_reg == tmi_pkg::PH_RUNNING) begin
                                k_next     = KW'(TA - 1);
                                state_next = S_MOD;
                            end else if (check_reg) begin
                                idx_next   = '0;
                                depth_next = '0;
                                state_next = S_CHK_RD;
                            end else begin
                                fill_next  = '0;
                                ptr_next   = '0;
                                pc_next    = '0;
                                phase_next = tmi_pkg::PH_RUNNING;
                                state_next = S_CLR;
                            end
                        end
                        tmi_pkg::OP_SUPPLY: begin
                            if (phase_reg == tmi_pkg::PH_WAITING) begin
                                sup_next      = 1'b1;
                                sup_byte_next = s_tdata[7:0];
                                sup_eof_next  = s_tdata[8];
                                k_next        = KW'(TA - 1);
                                state_next    = S_MOD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_CHK_RD: begin
                prog_raddr = idx_reg[PA-1:0];
                if (idx_reg == len_reg) begin
                    if (depth_reg == '0) begin
                        fill_next  = '0;
                        ptr_next   = '0;
                        pc_next    = '0;
                        phase_next = tmi_pkg::PH_RUNNING;
                        state_next = S_CLR;
                    end else begin
                        phase_next      = tmi_pkg::PH_HALTED;
                        res_status_next = tmi_pkg::ST_BRACKET;
                        state_next      = S_OUT;
                    end
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_CHK_RD;
                if (prog_rdata == tmi_pkg::CH_OPEN) begin
                    depth_next = depth_reg + 1'b1;
                end else if (prog_rdata == tmi_pkg::CH_CLOSE) begin
                    if (depth_reg == '0) begin
                        phase_next      = tmi_pkg::PH_HALTED;
                        res_status_next = tmi_pkg::ST_BRACKET;
                        state_next      = S_OUT;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
            end
            S_CLR: begin
                if (fill_reg < size) begin
                    tape_we    = 1'b1;
                    tape_waddr = fill_reg[TA-1:0];
                    tape_wdata = '0;
                    fill_next  = fill_reg + 1'b1;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_MOD: begin
                if (DW'(ptr_reg) >= sub_shifted) begin
                    ptr_next = sub_diff[TA-1:0];
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (fill_reg < size) begin
                    state_next = S_CLR;
                end else if (sup_reg) begin
                    sup_next   = 1'b0;
                    tape_we    = 1'b1;
                    tape_wdata = sup_eof_reg ? '1 : CELL_BITS'(sup_byte_reg);
                    pc_next    = pc_reg + 1'b1;
                    phase_next = tmi_pkg::PH_RUNNING;
                end else if (pc_reg >= len_reg) begin
                    phase_next      = tmi_pkg::PH_HALTED;
                    res_status_next = tmi_pkg::ST_HALTED;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_FETCH;
                case (prog_rdata)
                    tmi_pkg::CH_RIGHT: begin
                        ptr_next = (SW'(ptr_reg) + 1'b1 == size) ? '0 : ptr_reg + 1'b1;
                    end
                    tmi_pkg::CH_LEFT: begin
                        ptr_next = (ptr_reg == '0) ? TA'(size - 1'b1) : ptr_reg - 1'b1;
                    end
                    tmi_pkg::CH_INC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + 1'b1;
                    end
                    tmi_pkg::CH_DEC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - 1'b1;
                    end
                    tmi_pkg::CH_OUT: begin
                        res_status_next = tmi_pkg::ST_OUTPUT;
                        res_byte_next   = tape_rdata[7:0];
                        state_next      = S_OUT;
                    end
                    tmi_pkg::CH_IN: begin
                        pc_next         = pc_reg;
                        phase_next      = tmi_pkg::PH_WAITING;
                        res_status_next = tmi_pkg::ST_NEED_INPUT;
                        state_next      = S_OUT;
                    end
                    tmi_pkg::CH_OPEN: begin
                        if (tape_rdata == '0) begin
                            pc_next    = pc_reg;
                            idx_next   = pc_reg + 1'b1;
                            depth_next = '0;
                            back_next  = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    tmi_pkg::CH_CLOSE: begin
                        if (tape_rdata != '0) begin
                            pc_next    = pc_reg;
                            idx_next   = pc_reg;
                            depth_next = '0;
                            back_next  = 1'b1;
                            state_next = S_SCAN_RD;
                        end
                    end
                    default: pc_next = pc_reg + 1'b1;
                endcase
            end
            S_SCAN_RD: begin
                if (back_reg) begin
                    prog_raddr = PA'(idx_reg - 1'b1);
                    if (idx_reg == '0) begin
                        pc_next    = len_reg;
                        state_next = S_FETCH;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_SCAN;
                    end
                end else begin
                    prog_raddr = idx_reg[PA-1:0];
                    if (idx_reg >= len_reg) begin
                        pc_next    = len_reg;
                        state_next = S_FETCH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                state_next = S_SCAN_RD;
                if (back_reg) begin
                    if (prog_rdata == tmi_pkg::CH_OPEN && depth_reg == '0) begin
                        pc_next    = idx_reg + 1'b1;
                        state_next = S_FETCH;
                    end else if (prog_rdata == tmi_pkg::CH_CLOSE) begin
                        depth_next = depth_reg + 1'b1;
                    end else if (prog_rdata == tmi_pkg::CH_OPEN) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (prog_rdata == tmi_pkg::CH_CLOSE && depth_reg == '0) begin
                        pc_next    = idx_reg + 1'b1;
                        state_next = S_FETCH;
                    end else if (prog_rdata == tmi_pkg::CH_OPEN) begin
                        depth_next = depth_reg + 1'b1;
                    end else if (prog_rdata == tmi_pkg::CH_CLOSE) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_byte_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= tmi_pkg::PH_LOADING;
            len_reg       <= '0;
            pc_reg        <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            depth_reg     <= '0;
            sup_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            tape_size_reg <= tmi_pkg::TAPE_SIZE_RST;
            check_reg     <= 1'b1;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            pc_reg        <= pc_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            depth_reg     <= depth_next;
            sup_reg       <= sup_next;
            m_tvalid_reg  <= m_tvalid_next;
            tape_size_reg <= tape_size_next;
            check_reg     <= check_next;
        end
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        back_reg       <= back_next;
        sup_byte_reg   <= sup_byte_next;
        sup_eof_reg    <= sup_eof_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(PROGRAM_DEPTH))
        else $error("program length beyond store depth");

    a_pc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH || state_reg == S_DEC) |-> pc_reg <= len_reg)
        else $error("program counter beyond program length");

    a_ptr_in_tape: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEC) |-> SW'(ptr_reg) < size)
        else $error("cell pointer outside tape in use");

    a_wait_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && res_status_reg == tmi_pkg::ST_NEED_INPUT)
        |-> phase_reg == tmi_pkg::PH_WAITING)
        else $error("input request without waiting phase");
`endif

endmodule
